/* sv/quad_x_motor_mixer_defines.svh */
// assertion macros for the quad x motor mixer
// used by modules that carry concurrent checks; needs clk and arst_n in scope
`ifndef QUAD_X_MOTOR_MIXER_DEFINES_SVH
`define QUAD_X_MOTOR_MIXER_DEFINES_SVH
`ifndef SYNTHESIS
`define QXMM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qxmm check failed: same cycle");
`define QXMM_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qxmm check failed: next cycle");
`else
`define QXMM_ASSERT_IMP(label, ante, cons)
`define QXMM_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* sv/qxmm_pkg.sv */
// types, constants and the battery sag gain table for the quad x motor mixer
// no dependencies
package qxmm_pkg;

	localparam int IN_BITS      = 65;
	localparam int IN_TDATA_W   = 72;
	localparam int OUT_BITS     = 44;
	localparam int OUT_TDATA_W  = 48;
	localparam int NUM_MOTORS   = 4;

	localparam logic [7:0] NOMINAL_VBAT = 8'd126;
	localparam logic [5:0] TABLE_TOP    = 6'd36;
	localparam logic signed [14:0] SAG_BASE = 15'sd1000;
	// floor(b / 125) = (b * DIV125_RECIP) >> DIV125_SHIFT for b below 2^18
	localparam logic [17:0] DIV125_RECIP = 18'd134218;
	localparam int          DIV125_SHIFT = 24;

	typedef enum logic [2:0] {
		CFG_MIN_THROTTLE     = 3'd0,
		CFG_MAX_THROTTLE     = 3'd1,
		CFG_MIN_CHECK        = 3'd2,
		CFG_MIN_COMMAND      = 3'd3,
		CFG_IDLE_STOP        = 3'd4,
		CFG_VOLT_COMP_ENABLE = 3'd5,
		CFG_VBAT_CRITICAL    = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [10:0] min_throttle;
		logic [10:0] max_throttle;
		logic [10:0] min_check;
		logic [10:0] min_command;
		logic        idle_stop;
		logic        volt_comp_enable;
		logic [6:0]  vbat_critical;
	} cfg_t;

	// last member sits in the lowest bits, matching the tdata layout
	typedef struct packed {
		logic [7:0]         battery_voltage;
		logic               armed;
		logic               baro_hold;
		logic [10:0]        throttle_stick;
		logic signed [10:0] yaw_correction;
		logic signed [10:0] pitch_correction;
		logic signed [10:0] roll_correction;
		logic [10:0]        throttle_command;
	} item_t;

	typedef struct packed {
		logic low_stick;
		logic armed;
	} ctl_t;

	typedef logic signed [14:0] mix_t;
	typedef logic signed [21:0] prod_t;
	typedef mix_t  [NUM_MOTORS-1:0] mix_vec_t;
	typedef prod_t [NUM_MOTORS-1:0] prod_vec_t;
	// index 0 rear right, 1 front right, 2 rear left, 3 front left
	typedef logic [NUM_MOTORS-1:0][10:0] mot_vec_t;

	localparam logic [6:0] SAG_GAIN [0:36] = '{
		7'd0,   7'd3,   7'd5,   7'd8,   7'd11,  7'd14,  7'd17,  7'd19,  7'd22,  7'd25,
		7'd28,  7'd31,  7'd34,  7'd38,  7'd41,  7'd44,  7'd47,  7'd51,  7'd54,  7'd58,
		7'd61,  7'd65,  7'd68,  7'd72,  7'd76,  7'd79,  7'd83,  7'd87,  7'd91,  7'd95,
		7'd99,  7'd104, 7'd108, 7'd112, 7'd117, 7'd121, 7'd126
	};

	function automatic logic [6:0] qxmm_gain(input logic [5:0] idx);
		logic [6:0] g;
		g = 7'd0;
		if (idx <= TABLE_TOP) begin
			g = SAG_GAIN[idx];
		end
		return g;
	endfunction

endpackage

/* sv/qxmm_mix.sv */
// mixing stage: four quad x motor sums and the sag gain product per motor
// depends on qxmm_pkg
module qxmm_mix (
	input  qxmm_pkg::item_t     item,
	input  qxmm_pkg::cfg_t      cfg,
	output qxmm_pkg::mix_vec_t  mix,
	output qxmm_pkg::prod_vec_t prod,
	output qxmm_pkg::ctl_t      ctl
);
	import qxmm_pkg::*;

	mix_t             t, r, p, y;
	logic [7:0]       vc;
	logic signed [8:0] d;
	logic [5:0]       v;
	logic [6:0]       gain;
	mix_t             diff [NUM_MOTORS];

	always_comb begin
		t = mix_t'({4'b0, item.throttle_command});
		r = {{4{item.roll_correction[10]}}, item.roll_correction};
		p = {{4{item.pitch_correction[10]}}, item.pitch_correction};
		y = {{4{item.yaw_correction[10]}}, item.yaw_correction};
		mix[0] = t - r + p - y;
		mix[1] = t - r - p + y;
		mix[2] = t + r + p + y;
		mix[3] = t + r - p - y;
	end

	// lower bound tested first, so a critical level above nominal wins
	always_comb begin
		if (item.battery_voltage < {1'b0, cfg.vbat_critical}) begin
			vc = {1'b0, cfg.vbat_critical};
		end else if (item.battery_voltage > NOMINAL_VBAT) begin
			vc = NOMINAL_VBAT;
		end else begin
			vc = item.battery_voltage;
		end
		d = signed'({1'b0, NOMINAL_VBAT}) - signed'({1'b0, vc});
		if (d < 0) begin
			v = 6'd0;
		end else if (d > signed'({3'b0, TABLE_TOP})) begin
			v = TABLE_TOP;
		end else begin
			v = d[5:0];
		end
		gain = qxmm_gain(v);
	end

	always_comb begin
		for (int i = 0; i < NUM_MOTORS; i++) begin
			diff[i] = mix[i] - SAG_BASE;
			prod[i] = prod_t'(diff[i]) * prod_t'(signed'({15'b0, gain}));
		end
	end

	assign ctl.low_stick = (item.throttle_stick < cfg.min_check) && !item.baro_hold;
	assign ctl.armed     = item.armed;

endmodule

/* sv/qxmm_comp.sv */
// compensation stage: divides the sag product by 500 toward zero and, when enabled, adds it
// depends on qxmm_pkg
module qxmm_comp (
	input  qxmm_pkg::mix_vec_t  mix,
	input  qxmm_pkg::prod_vec_t prod,
	input  logic                enable,
	output qxmm_pkg::mix_vec_t  comp
);
	import qxmm_pkg::*;

	logic        neg  [NUM_MOTORS];
	prod_t       absv [NUM_MOTORS];
	logic [17:0] quar [NUM_MOTORS];
	logic [35:0] qp   [NUM_MOTORS];
	logic [10:0] q    [NUM_MOTORS];
	mix_t        delta [NUM_MOTORS];

	// |prod| stays below 2^19; /500 is >>2 then a reciprocal multiply for /125
	always_comb begin
		for (int i = 0; i < NUM_MOTORS; i++) begin
			neg[i]   = prod[i][21];
			absv[i]  = neg[i] ? -prod[i] : prod[i];
			quar[i]  = absv[i][19:2];
			qp[i]    = {18'b0, quar[i]} * {18'b0, DIV125_RECIP};
			q[i]     = qp[i][DIV125_SHIFT+10:DIV125_SHIFT];
			delta[i] = neg[i] ? -mix_t'({4'b0, q[i]}) : mix_t'({4'b0, q[i]});
			comp[i]  = enable ? (mix[i] + delta[i]) : mix[i];
		end
	end

endmodule

/* sv/qxmm_limit.sv */
// limiting stage: shifts down by the excess over max throttle, clamps, overrides
// depends on qxmm_pkg
module qxmm_limit (
	input  qxmm_pkg::mix_vec_t comp,
	input  qxmm_pkg::ctl_t     ctl,
	input  qxmm_pkg::cfg_t     cfg,
	output qxmm_pkg::mot_vec_t motors
);
	import qxmm_pkg::*;

	mix_t lo, hi, top_a, top_b, top, excess;
	mix_t x [NUM_MOTORS];

	always_comb begin
		lo     = mix_t'({4'b0, cfg.min_throttle});
		hi     = mix_t'({4'b0, cfg.max_throttle});
		top_a  = (comp[1] > comp[0]) ? comp[1] : comp[0];
		top_b  = (comp[3] > comp[2]) ? comp[3] : comp[2];
		top    = (top_b > top_a) ? top_b : top_a;
		excess = (top > hi) ? (top - hi) : mix_t'(0);
		for (int i = 0; i < NUM_MOTORS; i++) begin
			x[i] = comp[i] - excess;
			priority if (x[i] < lo) begin
				motors[i] = cfg.min_throttle;
			end else if (x[i] > hi) begin
				motors[i] = cfg.max_throttle;
			end else begin
				motors[i] = x[i][10:0];
			end
			if (ctl.low_stick) begin
				motors[i] = cfg.idle_stop ? cfg.min_command : cfg.min_throttle;
			end
			if (!ctl.armed) begin
				motors[i] = cfg.min_command;
			end
		end
	end

endmodule

/* sv/quad_x_motor_mixer.sv */
// quad x motor mixer, top level: stream ports, config registers, pipeline
// path: item_s1, mix_s2, comp_s3 and motors_q register an accepted input request on its way to m_axis
// throughput: one request per cycle while m_axis is ready; each stage holds one request and moves on
// as soon as the stage after it has room, so output stalls back up in order
// reset: arst_n clears all stage valids and loads the config register defaults
// depends on qxmm_pkg, qxmm_mix, qxmm_comp, qxmm_limit, quad_x_motor_mixer_defines.svh
`include "quad_x_motor_mixer_defines.svh"
module quad_x_motor_mixer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// throttle_command, roll_correction, pitch_correction, yaw_correction,
	// throttle_stick, baro_hold, armed, battery_voltage, zero pad
	input  logic [qxmm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// motor_rear_right, motor_front_right, motor_rear_left, motor_front_left,
	// zero pad
	output logic [qxmm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [2:0]                       cfg_index,
	input  logic [10:0]                      cfg_data
);
	import qxmm_pkg::*;

	cfg_t      cfg_q;
	logic      valid_s1, valid_s2, valid_s3, out_valid_q;
	logic      ready_s1, ready_s2, ready_s3, ready_o;
	logic      out_load, out_run;
	item_t     item_s1;
	mix_vec_t  mix_s2;
	prod_vec_t prod_s2;
	ctl_t      ctl_s2, ctl_s3;
	mix_vec_t  comp_s3;
	mot_vec_t  motors_q;
	mix_vec_t  mix_c;
	prod_vec_t prod_c;
	ctl_t      ctl_c;
	mix_vec_t  comp_c;
	mot_vec_t  motors_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_throttle     <= 11'd1150;
			cfg_q.max_throttle     <= 11'd1850;
			cfg_q.min_check        <= 11'd1100;
			cfg_q.min_command      <= 11'd1000;
			cfg_q.idle_stop        <= 1'b0;
			cfg_q.volt_comp_enable <= 1'b0;
			cfg_q.vbat_critical    <= 7'd99;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MIN_THROTTLE:     cfg_q.min_throttle     <= cfg_data;
				CFG_MAX_THROTTLE:     cfg_q.max_throttle     <= cfg_data;
				CFG_MIN_CHECK:        cfg_q.min_check        <= cfg_data;
				CFG_MIN_COMMAND:      cfg_q.min_command      <= cfg_data;
				CFG_IDLE_STOP:        cfg_q.idle_stop        <= cfg_data[0];
				CFG_VOLT_COMP_ENABLE: cfg_q.volt_comp_enable <= cfg_data[0];
				CFG_VBAT_CRITICAL:    cfg_q.vbat_critical    <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// each stage loads when empty or when the next one moves
	assign ready_o  = !out_valid_q || m_axis_tready;
	assign ready_s3 = !valid_s3 || ready_o;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;

	assign out_load = valid_s3 && ready_o;
	// armed, stick not low and sane bounds: the result must sit inside the limits
	assign out_run  = out_load && ctl_s3.armed && !ctl_s3.low_stick
		&& (cfg_q.min_throttle <= cfg_q.max_throttle);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_o) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	qxmm_mix u_mix (
		.item (item_s1),
		.cfg  (cfg_q),
		.mix  (mix_c),
		.prod (prod_c),
		.ctl  (ctl_c)
	);

	qxmm_comp u_comp (
		.mix    (mix_s2),
		.prod   (prod_s2),
		.enable (cfg_q.volt_comp_enable),
		.comp   (comp_c)
	);

	qxmm_limit u_limit (
		.comp   (comp_s3),
		.ctl    (ctl_s3),
		.cfg    (cfg_q),
		.motors (motors_c)
	);

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && ready_s1) begin
			item_s1 <= item_t'(s_axis_tdata[IN_BITS-1:0]);
		end
		if (valid_s1 && ready_s2) begin
			mix_s2  <= mix_c;
			prod_s2 <= prod_c;
			ctl_s2  <= ctl_c;
		end
		if (valid_s2 && ready_s3) begin
			comp_s3 <= comp_c;
			ctl_s3  <= ctl_s2;
		end
		if (out_load) begin
			motors_q <= motors_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - OUT_BITS)'(0), motors_q};

	`QXMM_ASSERT_NXT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready, valid_s1)
	`QXMM_ASSERT_IMP(a_empty_s1_ready, !valid_s1, s_axis_tready)
	`QXMM_ASSERT_NXT(a_disarmed_rr, out_load && !ctl_s3.armed, motors_q[0] == cfg_q.min_command)
	`QXMM_ASSERT_NXT(a_disarmed_fl, out_load && !ctl_s3.armed, motors_q[3] == cfg_q.min_command)
	`QXMM_ASSERT_NXT(a_rr_above_min, out_run, motors_q[0] >= cfg_q.min_throttle)
	`QXMM_ASSERT_NXT(a_rr_below_max, out_run, motors_q[0] <= cfg_q.max_throttle)

endmodule
